// ===== src/rpdc_pkg.sv =====
// ----------------------------------------------------------------------------
// rpdc_pkg
// Shared types, constants and helper functions for the RC pulse drive commander.
// ----------------------------------------------------------------------------
package rpdc_pkg;

	localparam int COUNT_BITS = 16;
	localparam int WIDTH_BITS = COUNT_BITS + 1;
	localparam int NUM_CH     = 4;
	localparam int NUM_BYTES  = 18;
	localparam int IDX_BITS   = $clog2(NUM_BYTES);
	localparam int FC_BITS    = 32;

	// channel order on the input word
	localparam int CH_FWD    = 0;
	localparam int CH_TURN   = 1;
	localparam int CH_STOP   = 2;
	localparam int CH_MANUAL = 3;

	// configuration register indexes
	localparam logic [1:0] CFG_WIDTH_OFFSET = 2'd0;
	localparam logic [1:0] CFG_PULSE_THRESH = 2'd1;
	localparam logic [1:0] CFG_FLASH_HALF   = 2'd2;

	localparam logic [9:0]  RST_WIDTH_OFFSET = 10'd243;
	localparam logic [3:0]  RST_PULSE_THRESH = 4'd8;
	localparam logic [19:0] RST_FLASH_HALF   = 20'd100000;
	localparam logic [3:0]  TOTAL_MAX        = 4'd15;

	// status frame bytes
	localparam logic [7:0] HDR_HASH   = 8'h23;
	localparam logic [7:0] HDR_PCT    = 8'h25;
	localparam logic [7:0] HDR_ID     = 8'h82;
	localparam logic [7:0] HDR_ZERO   = 8'h00;
	localparam logic [7:0] FILL_ON    = 8'hFF;
	localparam logic [7:0] FILL_OFF   = 8'h00;
	localparam logic [7:0] CHK_MANUAL =
		8'(HDR_HASH + HDR_PCT + HDR_ID + HDR_ZERO + 3 * FILL_ON);
	localparam logic [7:0] CHK_AUTO   =
		8'(HDR_HASH + HDR_PCT + HDR_ID + HDR_ZERO + 3 * FILL_OFF);

	// motor command bytes
	localparam logic [7:0] CMD_BANG   = 8'h21;
	localparam logic [7:0] CMD_RIGHT  = 8'h41;
	localparam logic [7:0] CMD_LEFT   = 8'h42;
	localparam logic [7:0] CMD_LOWER  = 8'h20;
	localparam logic [7:0] CMD_CR     = 8'h0D;

	localparam logic [0:0] PORT_STATUS = 1'b0;
	localparam logic [0:0] PORT_MOTOR  = 1'b1;

	typedef logic signed [WIDTH_BITS-1:0] width_t;

	typedef struct packed {
		logic       manual_frame;
		logic       light;
		logic       mode;
		logic       stop;
		logic       right_neg;
		logic [7:0] right_mag;
		logic       left_neg;
		logic [7:0] left_mag;
	} frame_t;

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		hex_char = (v > 4'd9) ? (8'(v) + 8'h37) : (8'(v) + 8'h30);
	endfunction

	// signed halving, truncated toward zero
	function automatic width_t half_tz(input width_t v);
		width_t t;
		t = v + $signed({{(WIDTH_BITS-1){1'b0}}, v[WIDTH_BITS-1]});
		half_tz = t >>> 1;
	endfunction

endpackage

// ===== src/rpdc_reader.sv =====
// ----------------------------------------------------------------------------
// rpdc_reader
// Per-channel pulse width measurement, pulse total and phase control.
// ----------------------------------------------------------------------------
module rpdc_reader import rpdc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic [NUM_CH-1:0] levels,
	input  logic [9:0]        width_offset,
	input  logic [3:0]        pulse_threshold,
	output logic              serial,
	output width_t            widths [NUM_CH]
);

	logic [NUM_CH-1:0]     high_q;
	logic [COUNT_BITS-1:0] count_q [NUM_CH];
	width_t                width_q [NUM_CH];
	logic [3:0]            total_q;
	logic                  serial_q;

	logic [COUNT_BITS-1:0] count_inc [NUM_CH];
	logic [NUM_CH-1:0]     done;
	logic [4:0]            total_sum;
	logic [3:0]            total_sat;

	always_comb begin
		for (int i = 0; i < NUM_CH; i++) begin
			count_inc[i] = (&count_q[i]) ? count_q[i] : count_q[i] + 1'b1;
			done[i]      = high_q[i] && !levels[i];
		end
		total_sum = 5'(total_q) + 5'($countones(done));
		total_sat = (total_sum > 5'(TOTAL_MAX)) ? TOTAL_MAX : total_sum[3:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_q   <= '0;
			total_q  <= '0;
			serial_q <= 1'b0;
			for (int i = 0; i < NUM_CH; i++) begin
				count_q[i] <= '0;
				width_q[i] <= '0;
			end
		end else if (fire) begin
			if (serial_q) begin
				serial_q <= 1'b0;
			end else begin
				for (int i = 0; i < NUM_CH; i++) begin
					if (!high_q[i]) begin
						if (levels[i]) begin
							count_q[i] <= COUNT_BITS'(1);
							high_q[i]  <= 1'b1;
						end
					end else begin
						count_q[i] <= count_inc[i];
						if (!levels[i]) begin
							width_q[i] <= $signed({1'b0, count_inc[i]})
								- $signed(WIDTH_BITS'(width_offset));
							high_q[i]  <= 1'b0;
						end
					end
				end
				if (total_sat > pulse_threshold) begin
					total_q  <= '0;
					serial_q <= 1'b1;
				end else begin
					total_q <= total_sat;
				end
			end
		end
	end

	assign serial = serial_q;
	assign widths = width_q;

endmodule

// ===== src/rpdc_mixer.sv =====
// ----------------------------------------------------------------------------
// rpdc_mixer
// Mode decision, flash counter and differential motor mix for one frame.
// ----------------------------------------------------------------------------
module rpdc_mixer import rpdc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  logic        serial,
	input  width_t      widths [NUM_CH],
	input  logic [19:0] flash_half_period,
	output frame_t      frame
);

	logic [FC_BITS-1:0] fc_q;
	logic [FC_BITS-1:0] half_ext;
	logic [FC_BITS-1:0] fc_base;
	logic               fc_neg;
	logic               stop;
	logic               manual;
	width_t             fwd;
	width_t             turn;
	width_t             right;
	width_t             left;
	logic [7:0]         right_neg_lo;
	logic [7:0]         left_neg_lo;

	function automatic logic is_pos(input width_t v);
		is_pos = !v[WIDTH_BITS-1] && (|v);
	endfunction

	always_comb begin
		half_ext = FC_BITS'(flash_half_period);
		fc_neg   = fc_q[FC_BITS-1];
		stop     = !is_pos(widths[CH_STOP]);
		manual   = stop || is_pos(widths[CH_MANUAL]);

		fc_base = fc_q;
		if (serial && !manual && !fc_neg && (fc_q > half_ext)) begin
			fc_base = '0 - half_ext;
		end

		fwd          = half_tz(widths[CH_FWD]);
		turn         = half_tz(widths[CH_TURN]);
		right        = fwd + turn;
		left         = fwd - turn;
		right_neg_lo = ~right[7:0] + 8'd1;
		left_neg_lo  = ~left[7:0] + 8'd1;

		frame.manual_frame = manual;
		frame.light        = manual || ((|fc_q) && !fc_neg);
		frame.mode         = manual;
		frame.stop         = stop;
		frame.right_neg    = !stop && right[WIDTH_BITS-1];
		frame.left_neg     = !stop && left[WIDTH_BITS-1];
		frame.right_mag    = stop ? 8'd0 : (right[WIDTH_BITS-1] ? right_neg_lo : right[7:0]);
		frame.left_mag     = stop ? 8'd0 : (left[WIDTH_BITS-1] ? left_neg_lo : left[7:0]);
	end

	// counter advances on every accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q <= '0;
		end else if (fire) begin
			fc_q <= fc_base + 1'b1;
		end
	end

endmodule

// ===== src/rpdc_emitter.sv =====
// ----------------------------------------------------------------------------
// rpdc_emitter
// Frame register and byte sequencer feeding the output word register.
// ----------------------------------------------------------------------------
module rpdc_emitter import rpdc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  frame_t      frame,
	output logic        busy,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_data,
	output logic        out_port,
	output logic        out_last,
	output logic        out_light,
	output logic        out_mode,
	output logic        out_stop
);

	frame_t              frame_q;
	logic                pend_q;
	logic [IDX_BITS-1:0] idx_q;
	logic                valid_q;
	logic [7:0]          data_q;
	logic                port_q;
	logic                last_q;
	logic                light_q;
	logic                mode_q;
	logic                stop_q;

	logic [7:0] bytes [NUM_BYTES];
	logic [7:0] fill;
	logic [7:0] right_letter;
	logic [7:0] left_letter;
	logic       advance;
	logic       at_end;

	always_comb begin
		fill         = frame_q.manual_frame ? FILL_ON : FILL_OFF;
		right_letter = frame_q.right_neg ? (CMD_RIGHT + CMD_LOWER) : CMD_RIGHT;
		left_letter  = frame_q.left_neg ? (CMD_LEFT + CMD_LOWER) : CMD_LEFT;

		bytes[0]  = HDR_HASH;
		bytes[1]  = HDR_PCT;
		bytes[2]  = HDR_ID;
		bytes[3]  = HDR_ZERO;
		bytes[4]  = fill;
		bytes[5]  = fill;
		bytes[6]  = fill;
		bytes[7]  = frame_q.manual_frame ? CHK_MANUAL : CHK_AUTO;
		bytes[8]  = CMD_BANG;
		bytes[9]  = right_letter;
		bytes[10] = hex_char(frame_q.right_mag[7:4]);
		bytes[11] = hex_char(frame_q.right_mag[3:0]);
		bytes[12] = CMD_CR;
		bytes[13] = CMD_BANG;
		bytes[14] = left_letter;
		bytes[15] = hex_char(frame_q.left_mag[7:4]);
		bytes[16] = hex_char(frame_q.left_mag[3:0]);
		bytes[17] = CMD_CR;

		advance = pend_q && (!valid_q || out_ready);
		at_end  = (idx_q == IDX_BITS'(NUM_BYTES - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= 1'b0;
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				pend_q <= 1'b1;
				idx_q  <= '0;
			end else if (advance) begin
				idx_q <= at_end ? '0 : idx_q + 1'b1;
				if (at_end) begin
					pend_q <= 1'b0;
				end
			end
			if (advance) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			frame_q <= frame;
		end
		if (advance) begin
			data_q  <= bytes[idx_q];
			port_q  <= (idx_q < IDX_BITS'(8)) ? PORT_STATUS : PORT_MOTOR;
			last_q  <= at_end;
			light_q <= frame_q.light;
			mode_q  <= frame_q.mode;
			stop_q  <= frame_q.stop;
		end
	end

	assign busy      = pend_q;
	assign out_valid = valid_q;
	assign out_data  = data_q;
	assign out_port  = port_q;
	assign out_last  = last_q;
	assign out_light = light_q;
	assign out_mode  = mode_q;
	assign out_stop  = stop_q;

endmodule

// ===== src/rc_pulse_drive_commander_top.sv =====
// ----------------------------------------------------------------------------
// rc_pulse_drive_commander_top
// RC receiver pulse decoder with status frame and differential motor output.
//
//  channel  | dir | fields
//  s_axis   | in  | tdata[3:0] forward, turn, stop, manual pin levels
//  m_axis   | out | tdata data_byte, light_on, manual_pin, stop_active;
//           |     | tuser port_select; tlast last_byte
//  cfg      | in  | cfg_we, cfg_index, cfg_data (offset, threshold, half period)
//
// read-phase samples are taken one per cycle and give no output words.
// a serial tick loads an 18-word frame; the byte sequencer then sends one word
// a cycle through the output register while m_axis_tready holds high.
// read samples keep flowing while a frame drains; the next serial tick waits
// until the frame register is free. arst_n clears all control state.
// ----------------------------------------------------------------------------
module rc_pulse_drive_commander_top import rpdc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // forward, turn, stop, manual, zero pad
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // data_byte[7:0], light_on, manual_pin,
	                                    // stop_active, zero pad
	output logic        m_axis_tlast,
	output logic        m_axis_tuser,   // port_select
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [19:0] cfg_data
);

	logic [9:0]  width_offset_q;
	logic [3:0]  pulse_threshold_q;
	logic [19:0] flash_half_q;

	logic   fire;
	logic   rd_serial;
	logic   emit_busy;
	width_t widths [NUM_CH];
	frame_t frame;
	logic [7:0] out_data;
	logic   out_light;
	logic   out_mode;
	logic   out_stop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_offset_q    <= RST_WIDTH_OFFSET;
			pulse_threshold_q <= RST_PULSE_THRESH;
			flash_half_q      <= RST_FLASH_HALF;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WIDTH_OFFSET: width_offset_q    <= cfg_data[9:0];
				CFG_PULSE_THRESH: pulse_threshold_q <= cfg_data[3:0];
				CFG_FLASH_HALF:   flash_half_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	assign s_axis_tready = !rd_serial || !emit_busy;
	assign fire          = s_axis_tvalid && s_axis_tready;

	rpdc_reader u_reader (
		.clk             (clk),
		.arst_n          (arst_n),
		.fire            (fire),
		.levels          (s_axis_tdata[NUM_CH-1:0]),
		.width_offset    (width_offset_q),
		.pulse_threshold (pulse_threshold_q),
		.serial          (rd_serial),
		.widths          (widths)
	);

	rpdc_mixer u_mixer (
		.clk               (clk),
		.arst_n            (arst_n),
		.fire              (fire),
		.serial            (rd_serial),
		.widths            (widths),
		.flash_half_period (flash_half_q),
		.frame             (frame)
	);

	rpdc_emitter u_emitter (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire && rd_serial),
		.frame     (frame),
		.busy      (emit_busy),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (out_data),
		.out_port  (m_axis_tuser),
		.out_last  (m_axis_tlast),
		.out_light (out_light),
		.out_mode  (out_mode),
		.out_stop  (out_stop)
	);

	assign m_axis_tdata = {5'b0, out_stop, out_mode, out_light, out_data};

	// a serial tick always leaves a frame pending
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && rd_serial) |=> emit_busy)
		else $error("serial tick did not load a frame");

	// serial phase lasts exactly one accepted tick
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && rd_serial) |=> !rd_serial)
		else $error("serial phase did not end");

	// the final word of a frame is a motor command byte
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser == PORT_MOTOR))
		else $error("last word not on motor port");

	// emergency stop always reports manual mode
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && out_stop) |-> (out_mode && out_light))
		else $error("stop word without manual mode");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for rc_pulse_drive_commander_top: pin samples go in as
// stream words in random bursts, the pulse decoder and mixer are predicted
// alongside, and every serial word out is compared with the predicted byte.
// ----------------------------------------------------------------------------
module tb;
	import rpdc_pkg::*;

	localparam int     SETTLE      = 40;
	localparam int     QUIET_LIMIT = 1000;
	localparam longint COUNT_MAX   = (longint'(1) << COUNT_BITS) - 1;

	// opening sweep at reset values, played from the left
	localparam int             OPENING_LEN = 20;
	localparam logic [4*20-1:0] OPENING = {
		4'h0, 4'hF, 4'h0, 4'hF, 4'h0, 4'hF, 4'h0, 4'hF, 4'h1, 4'h3,
		4'h6, 4'hC, 4'h8, 4'h0, 4'h5, 4'hA, 4'h5, 4'hA, 4'h0, 4'h0
	};

	typedef enum logic [1:0] {RX_OPEN, RX_CHOPPY, RX_CHOKED} rx_mode_e;

	typedef struct packed {
		logic       port;
		logic [7:0] data;
		logic       last;
		logic       light;
		logic       mode;
		logic       stop;
	} serial_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;     // forward, turn, stop, manual, zero pad
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;          // data_byte[7:0], light_on, manual_pin,
	                                    // stop_active, zero pad
	logic        m_axis_tlast;
	logic        m_axis_tuser;          // port_select
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [19:0] cfg_data = '0;

	// predicted decoder state
	logic [9:0]  offset_reg = RST_WIDTH_OFFSET;
	logic [3:0]  thresh_reg = RST_PULSE_THRESH;
	logic [19:0] half_reg = RST_FLASH_HALF;
	logic [3:0]  ch_high = '0;
	longint      ch_count[NUM_CH];
	longint      ch_width[NUM_CH];
	int          pulse_total = 0;
	logic        serial_due = 1'b0;
	logic [31:0] flash_cnt = '0;
	logic        stop_q = 1'b0;
	logic        light_q = 1'b0;
	logic        mode_q = 1'b0;

	logic [3:0]   pin_samples[$];
	serial_byte_t bytes_due[$];
	int           samples_unsent = 0;
	int           bad_words = 0;
	int           quiet_cycles = 0;
	int           burst_left = 0;
	int           gap_left = 0;
	rx_mode_e     rx_mode = RX_OPEN;
	int           rx_left = 0;
	serial_byte_t got, want;
	logic [3:0]   gen_level = '0;
	int           gen_run[NUM_CH];

	rc_pulse_drive_commander_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [7:0] ascii_hex(input logic [3:0] nib);
		return (nib > 4'd9) ? 8'h37 + 8'(nib) : 8'h30 + 8'(nib);
	endfunction

	task automatic push_byte(input logic port, input logic [7:0] data, input logic last);
		serial_byte_t b;
		b = {port, data, last, light_q, mode_q, stop_q};
		bytes_due.push_back(b);
	endtask

	task automatic push_motor(input longint v, input logic [7:0] letter, input logic last);
		longint mag;
		mag = (v < 0) ? -v : v;
		push_byte(PORT_MOTOR, CMD_BANG, 1'b0);
		push_byte(PORT_MOTOR, (v < 0) ? letter + CMD_LOWER : letter, 1'b0);
		push_byte(PORT_MOTOR, ascii_hex(mag[7:4]), 1'b0);
		push_byte(PORT_MOTOR, ascii_hex(mag[3:0]), 1'b0);
		push_byte(PORT_MOTOR, CMD_CR, last);
	endtask

	// one accepted sample tick: either measure pulses or emit the serial bytes
	task automatic advance_decoder(input logic [3:0] pins);
		int         finished;
		longint     right_cmd, left_cmd;
		logic [7:0] fill, csum;
		logic       manual_frame;
		if (!serial_due) begin
			finished = 0;
			for (int ch = 0; ch < NUM_CH; ch++) begin
				if (!ch_high[ch]) begin
					if (pins[ch]) begin
						ch_count[ch] = 1;
						ch_high[ch] = 1'b1;
					end
				end else begin
					if (ch_count[ch] < COUNT_MAX)
						ch_count[ch]++;
					if (!pins[ch]) begin
						ch_width[ch] = ch_count[ch] - longint'(offset_reg);
						ch_high[ch] = 1'b0;
						finished++;
					end
				end
			end
			pulse_total = pulse_total + finished;
			if (pulse_total > TOTAL_MAX)
				pulse_total = TOTAL_MAX;
			if (pulse_total > thresh_reg) begin
				pulse_total = 0;
				serial_due = 1'b1;
			end
		end else begin
			stop_q = !(ch_width[CH_STOP] > 0);
			if (stop_q || ch_width[CH_MANUAL] > 0) begin
				light_q = 1'b1;
				mode_q = 1'b1;
				manual_frame = 1'b1;
			end else begin
				light_q = (flash_cnt != 0) && !flash_cnt[31];
				// flash counter flips negative once past the half period
				if (!flash_cnt[31] && flash_cnt > {12'd0, half_reg})
					flash_cnt = 32'd0 - {12'd0, half_reg};
				mode_q = 1'b0;
				manual_frame = 1'b0;
			end
			fill = manual_frame ? FILL_ON : FILL_OFF;
			csum = HDR_HASH + HDR_PCT + HDR_ID + HDR_ZERO + fill + fill + fill;
			push_byte(PORT_STATUS, HDR_HASH, 1'b0);
			push_byte(PORT_STATUS, HDR_PCT, 1'b0);
			push_byte(PORT_STATUS, HDR_ID, 1'b0);
			push_byte(PORT_STATUS, HDR_ZERO, 1'b0);
			repeat (3) push_byte(PORT_STATUS, fill, 1'b0);
			push_byte(PORT_STATUS, csum, 1'b0);
			right_cmd = ch_width[CH_FWD] / 2 + ch_width[CH_TURN] / 2;
			left_cmd = ch_width[CH_FWD] / 2 - ch_width[CH_TURN] / 2;
			if (stop_q) begin
				right_cmd = 0;
				left_cmd = 0;
			end
			push_motor(right_cmd, CMD_RIGHT, 1'b0);
			push_motor(left_cmd, CMD_LEFT, 1'b1);
			serial_due = 1'b0;
		end
		flash_cnt = flash_cnt + 32'd1;
	endtask

	// sender: bursts of random length with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				advance_decoder(s_axis_tdata[3:0]);
				samples_unsent--;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left > 0 || pin_samples.size() == 0) begin
					if (gap_left > 0)
						gap_left--;
					s_axis_tvalid <= 1'b0;
				end else begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {4'b0000, pin_samples.pop_front()};
					if (burst_left == 0)
						burst_left = $urandom_range(1, 40);
					burst_left--;
					if (burst_left == 0)
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
		end
	end

	// receiver: checks each word and drives ready in open, choppy or choked stretches
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_mode = RX_OPEN;
			rx_left = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = {m_axis_tuser, m_axis_tdata[7:0], m_axis_tlast,
					m_axis_tdata[8], m_axis_tdata[9], m_axis_tdata[10]};
				if (bytes_due.size() == 0) begin
					bad_words++;
					if (bad_words <= 10)
						$display({"unexpected word: port=%0d byte=%h last=%0d",
							" light=%0d mode=%0d stop=%0d"},
							got.port, got.data, got.last, got.light, got.mode, got.stop);
				end else begin
					want = bytes_due.pop_front();
					if (got !== want) begin
						bad_words++;
						if (bad_words <= 10)
							$display({"word mismatch: expected port=%0d byte=%h last=%0d",
								" light=%0d mode=%0d stop=%0d, got port=%0d byte=%h",
								" last=%0d light=%0d mode=%0d stop=%0d"},
								want.port, want.data, want.last, want.light, want.mode,
								want.stop, got.port, got.data, got.last, got.light,
								got.mode, got.stop);
					end
				end
			end
			if (rx_left == 0) begin
				rx_mode = rx_mode_e'($urandom_range(0, 2));
				rx_left = $urandom_range(16, 96);
			end
			rx_left--;
			case (rx_mode)
				RX_OPEN:   m_axis_tready <= 1'b1;
				RX_CHOPPY: m_axis_tready <= 1'($urandom_range(0, 1));
				default:   m_axis_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles = 0;
		else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	task automatic queue_tick(input logic [3:0] pins);
		pin_samples.push_back(pins);
		samples_unsent++;
	endtask

	task automatic drain();
		while (samples_unsent != 0 || bytes_due.size() != 0)
			@(posedge clk);
		// serial ticks give no word until the frame register frees up
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [19:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_WIDTH_OFFSET: offset_reg = val[9:0];
			CFG_PULSE_THRESH: thresh_reg = val[3:0];
			CFG_FLASH_HALF:   half_reg = val;
			default: ;
		endcase
	endtask

	// reconfigure, then queue receiver-like pulse trains with some pin noise
	task automatic run_phase(input int offset, input int thresh, input int half,
		input int ticks, input int hi_max);
		logic [3:0] pins;
		drain();
		write_reg(CFG_WIDTH_OFFSET, 20'(offset));
		write_reg(CFG_PULSE_THRESH, 20'(thresh));
		write_reg(CFG_FLASH_HALF, 20'(half));
		@(posedge clk);
		cfg_we <= 1'b0;
		for (int t = 0; t < ticks; t++) begin
			if ($urandom_range(0, 9) == 0)
				pins = 4'($urandom);
			else begin
				for (int ch = 0; ch < NUM_CH; ch++) begin
					if (gen_run[ch] == 0) begin
						gen_level[ch] = !gen_level[ch];
						gen_run[ch] = gen_level[ch] ? $urandom_range(1, hi_max)
							: $urandom_range(1, 4);
					end
					gen_run[ch]--;
				end
				pins = gen_level;
			end
			queue_tick(pins);
		end
	endtask

	initial begin
		for (int ch = 0; ch < NUM_CH; ch++) begin
			ch_count[ch] = 0;
			ch_width[ch] = 0;
			gen_run[ch] = 0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < OPENING_LEN; i++)
			queue_tick(OPENING[4*(OPENING_LEN-1-i) +: 4]);

		run_phase(4, 0, 0, 50, 8);          // zero half period, every pulse fires
		run_phase(0, 3, 1, 60, 10);
		run_phase(12, 8, 20, 80, 28);
		run_phase(30, 2, 1048575, 70, 64);
		run_phase(8, 15, 60, 30, 18);       // threshold never reached
		run_phase(8, 5, 100000, 60, 20);    // saturated total fires at once
		run_phase(1023, 1, 7, 40, 10);

		drain();
		if (bad_words == 0 && bytes_due.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== sim.f =====
src/rpdc_pkg.sv
src/rpdc_reader.sv
src/rpdc_mixer.sv
src/rpdc_emitter.sv
src/rc_pulse_drive_commander_top.sv
dv/tb.sv
